// ----- src/asta_pkg.sv -----
// ----------------------------------------------------------------------------
// Sensor advertisement sampler - shared definitions
// Constants, record types and divider reciprocals used by the sampler blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package asta_pkg;

  // Packet walk limits and field layout.
  localparam int unsigned MAX_ADV_BYTES = 32;
  localparam int unsigned BYTE_IDX_W    = 8;
  localparam int unsigned FIELD_POS_W   = BYTE_IDX_W + 1;
  localparam int unsigned PREFIX_LEN    = 5;
  localparam int unsigned MARK_W        = PREFIX_LEN + 2;
  localparam int unsigned CNT_FIRST     = 7;
  localparam int unsigned VAL_FIRST     = 11;
  localparam int unsigned WORD_BYTES    = 4;

  localparam logic [7:0] TYPE_NAME_SHORT = 8'h08;
  localparam logic [7:0] TYPE_NAME_FULL  = 8'h09;

  // "CO_S_" in order of arrival.
  localparam logic [7:0] NAME_PREFIX [PREFIX_LEN] = '{8'h43, 8'h4F, 8'h5F, 8'h53, 8'h5F};

  // Window statistics.
  localparam int unsigned WINDOW_LEN = 5;
  localparam int unsigned TRIM_LEN   = WINDOW_LEN - 2;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned DATA_W     = 32;

  // Exact unsigned division of a 32-bit value by a small constant:
  // q = (x * ceil(2^(32+s) / d)) >> (32+s), with s = ceil(log2(d)).
  localparam int unsigned RECIP_W  = DATA_W + 1;
  localparam int unsigned PROD_W   = DATA_W + RECIP_W;
  localparam int unsigned ALL_SH   = DATA_W + $clog2(WINDOW_LEN);
  localparam int unsigned TRIM_SH  = DATA_W + $clog2(TRIM_LEN);
  localparam logic [RECIP_W-1:0] ALL_RECIP = RECIP_W'(
      ((PROD_W'(1) << ALL_SH) + PROD_W'(WINDOW_LEN) - PROD_W'(1)) / PROD_W'(WINDOW_LEN));
  localparam logic [RECIP_W-1:0] TRIM_RECIP = RECIP_W'(
      ((PROD_W'(1) << TRIM_SH) + PROD_W'(TRIM_LEN) - PROD_W'(1)) / PROD_W'(TRIM_LEN));

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NOTIFY_ENABLE   = 1'd1;

  // What the parser hands over at the end of a packet.
  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] counter;
    logic [DATA_W-1:0] value;
  } pkt_rec_t;

  // Per-packet flags that travel down the statistics pipeline.
  typedef struct packed {
    logic found;
    logic taken;
    logic done;
  } pkt_flags_t;

endpackage

`default_nettype wire

// ----- src/asta_in_if.sv -----
// ----------------------------------------------------------------------------
// Sensor advertisement sampler - byte input channel
// Valid/ready channel that carries one advertisement byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface asta_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] adv_byte;
  logic       last_byte;

  modport source (output valid, output adv_byte, output last_byte, input ready);
  modport sink   (input valid, input adv_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- src/asta_out_if.sv -----
// ----------------------------------------------------------------------------
// Sensor advertisement sampler - result channel
// Valid/ready channel that carries one packet result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface asta_out_if;
  logic        valid;
  logic        ready;
  logic        name_found;
  logic        sample_taken;
  logic        window_done;
  logic [31:0] mean_all;
  logic [31:0] mean_trimmed;
  logic        alarm;

  modport source (output valid, output name_found, output sample_taken,
                  output window_done, output mean_all, output mean_trimmed,
                  output alarm, input ready);
  modport sink   (input valid, input name_found, input sample_taken,
                  input window_done, input mean_all, input mean_trimmed,
                  input alarm, output ready);
endinterface

`default_nettype wire

// ----- src/asta_parser.sv -----
// ----------------------------------------------------------------------------
// Sensor advertisement sampler - packet parser
// Walks the length-type fields one byte per cycle while bytes are taken,
// detects the name prefix and assembles the counter and value words.
// ----------------------------------------------------------------------------
`default_nettype none

module asta_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        adv_byte,
  input  wire logic              last_byte,
  output asta_pkg::pkt_rec_t     rec
);

  logic [asta_pkg::BYTE_IDX_W-1:0]  byte_index, byte_index_next;
  logic [asta_pkg::FIELD_POS_W-1:0] next_field_start, next_field_start_next;
  logic [7:0]                       recent [asta_pkg::PREFIX_LEN];
  logic [7:0]                       recent_next [asta_pkg::PREFIX_LEN];
  logic [asta_pkg::MARK_W-1:0]      start_marks, start_marks_next;
  logic                             prefix_seen, prefix_seen_next;
  logic [asta_pkg::DATA_W-1:0]      counter_word, counter_word_next;
  logic [asta_pkg::DATA_W-1:0]      value_word, value_word_next;

  always_comb begin
    logic                        active;
    logic                        is_start;
    logic                        match;
    logic [asta_pkg::MARK_W-1:0] marks_shift;
    logic [1:0]                  lane;

    active      = byte_index < asta_pkg::BYTE_IDX_W'(asta_pkg::MAX_ADV_BYTES);
    is_start    = asta_pkg::FIELD_POS_W'(byte_index) == next_field_start;
    marks_shift = {start_marks[asta_pkg::MARK_W-2:0], is_start};

    // The name field's type byte sits PREFIX_LEN bytes back and its length
    // byte one further; the current byte closes the prefix.
    match = marks_shift[asta_pkg::MARK_W-1] &&
            (recent[asta_pkg::PREFIX_LEN-1] == asta_pkg::TYPE_NAME_SHORT ||
             recent[asta_pkg::PREFIX_LEN-1] == asta_pkg::TYPE_NAME_FULL) &&
            adv_byte == asta_pkg::NAME_PREFIX[asta_pkg::PREFIX_LEN-1];
    for (int k = 0; k < asta_pkg::PREFIX_LEN - 1; k++) begin
      match = match && (recent[asta_pkg::PREFIX_LEN-2-k] == asta_pkg::NAME_PREFIX[k]);
    end

    byte_index_next       = byte_index;
    next_field_start_next = next_field_start;
    recent_next           = recent;
    start_marks_next      = start_marks;
    prefix_seen_next      = prefix_seen;
    counter_word_next     = counter_word;
    value_word_next       = value_word;
    lane                  = 2'd0;

    if (take && active) begin
      byte_index_next  = byte_index + asta_pkg::BYTE_IDX_W'(1);
      start_marks_next = marks_shift;
      if (is_start) begin
        next_field_start_next = asta_pkg::FIELD_POS_W'(byte_index) +
                                asta_pkg::FIELD_POS_W'(adv_byte) +
                                asta_pkg::FIELD_POS_W'(1);
      end
      prefix_seen_next = prefix_seen | match;
      recent_next[0]   = adv_byte;
      for (int k = 1; k < asta_pkg::PREFIX_LEN; k++) begin
        recent_next[k] = recent[k-1];
      end
      if (byte_index >= asta_pkg::BYTE_IDX_W'(asta_pkg::CNT_FIRST) &&
          byte_index < asta_pkg::BYTE_IDX_W'(asta_pkg::CNT_FIRST + asta_pkg::WORD_BYTES)) begin
        lane = 2'(byte_index - asta_pkg::BYTE_IDX_W'(asta_pkg::CNT_FIRST));
        counter_word_next[{lane, 3'b000} +: 8] = adv_byte;
      end else if (byte_index >= asta_pkg::BYTE_IDX_W'(asta_pkg::VAL_FIRST) &&
                   byte_index < asta_pkg::BYTE_IDX_W'(asta_pkg::VAL_FIRST +
                                                       asta_pkg::WORD_BYTES)) begin
        lane = 2'(byte_index - asta_pkg::BYTE_IDX_W'(asta_pkg::VAL_FIRST));
        value_word_next[{lane, 3'b000} +: 8] = adv_byte;
      end
    end

    rec.found   = prefix_seen_next;
    rec.counter = counter_word_next;
    rec.value   = value_word_next;

    // The packet state starts over after its last byte.
    if (take && last_byte) begin
      byte_index_next       = '0;
      next_field_start_next = '0;
      start_marks_next      = '0;
      prefix_seen_next      = 1'b0;
      counter_word_next     = '0;
      value_word_next       = '0;
      for (int k = 0; k < asta_pkg::PREFIX_LEN; k++) begin
        recent_next[k] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index       <= '0;
      next_field_start <= '0;
      start_marks      <= '0;
      prefix_seen      <= 1'b0;
      counter_word     <= '0;
      value_word       <= '0;
      for (int k = 0; k < asta_pkg::PREFIX_LEN; k++) begin
        recent[k] <= 8'd0;
      end
    end else begin
      byte_index       <= byte_index_next;
      next_field_start <= next_field_start_next;
      start_marks      <= start_marks_next;
      prefix_seen      <= prefix_seen_next;
      counter_word     <= counter_word_next;
      value_word       <= value_word_next;
      recent           <= recent_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/adv_sensor_sample_trimmed_alarm_unit.sv -----
// ----------------------------------------------------------------------------
// Sensor advertisement sampler with trimmed-mean alarm
// Parses advertisement bytes, collects windows of samples and raises an alarm.
// ----------------------------------------------------------------------------
// The block takes one advertisement byte per cycle while adv_in.ready is high
// and gives one result item for each byte marked last. The result is
// registered in turn as the packet record, the window update, the trimmed
// sum and the reciprocal multiplier quotients; the output register then
// holds it until taken. Up to five results wait in the four stages and the
// output register, so bytes keep being accepted while a result is stalled
// until all of them hold a packet.
`default_nettype none

module adv_sensor_sample_trimmed_alarm_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  asta_in_if.sink                                adv_in,
  asta_out_if.source                             result_out,
  input  wire logic                              cfg_write,
  input  wire logic [asta_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [asta_pkg::DATA_W-1:0]       cfg_data
);

  localparam int unsigned W = asta_pkg::DATA_W;

  // Configuration.
  logic [W-1:0] alarm_threshold;
  logic         notify_enable;

  // Packet record stage.
  asta_pkg::pkt_rec_t parse_rec;
  asta_pkg::pkt_rec_t s1_rec;
  logic               s1_valid;
  logic               take;

  // Window state and window stage.
  logic [W-1:0]                  last_counter;
  logic [W-1:0]                  win_sum, win_min, win_max;
  logic [asta_pkg::COUNT_W-1:0]  win_count;
  logic                          s2_valid;
  asta_pkg::pkt_flags_t          s2_flags;
  logic [W-1:0]                  s2_sum, s2_min, s2_max;

  // Trimmed sum stage.
  logic                 s3_valid;
  asta_pkg::pkt_flags_t s3_flags;
  logic [W-1:0]         s3_sum, s3_trim;

  // Quotient stage.
  logic                 s4_valid;
  asta_pkg::pkt_flags_t s4_flags;
  logic [W-1:0]         s4_mean_all, s4_mean_trim;

  // Output register.
  logic                 out_valid;
  asta_pkg::pkt_flags_t out_flags;
  logic [W-1:0]         out_mean_all, out_mean_trim;
  logic                 out_alarm;
  logic                 alarm_state;

  logic en1, en2, en3, en4, en5;

  // A stage moves when it is empty or the stage after it moves.
  assign en5 = !out_valid || result_out.ready;
  assign en4 = !s4_valid || en5;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;

  assign adv_in.ready = en1;
  assign take         = adv_in.valid && en1;

  asta_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .adv_byte  (adv_in.adv_byte),
    .last_byte (adv_in.last_byte),
    .rec       (parse_rec)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_threshold <= '0;
      notify_enable   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        asta_pkg::REG_ALARM_THRESHOLD: alarm_threshold <= cfg_data;
        asta_pkg::REG_NOTIFY_ENABLE:   notify_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Packet record.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take && adv_in.last_byte) begin
      s1_valid <= 1'b1;
    end else if (en2) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && adv_in.last_byte) begin
      s1_rec <= parse_rec;
    end
  end

  // Window update.
  logic                         w_taken, w_first, w_done;
  logic [W-1:0]                 w_sum, w_min, w_max;
  logic [asta_pkg::COUNT_W-1:0] w_count;

  always_comb begin
    w_taken = s1_rec.found && (s1_rec.counter != last_counter);
    w_first = win_count == '0;
    w_min   = (w_first || s1_rec.value < win_min) ? s1_rec.value : win_min;
    w_max   = (w_first || s1_rec.value > win_max) ? s1_rec.value : win_max;
    w_sum   = (w_first ? '0 : win_sum) + s1_rec.value;
    w_count = win_count + asta_pkg::COUNT_W'(1);
    w_done  = w_taken && (w_count >= asta_pkg::COUNT_W'(asta_pkg::WINDOW_LEN));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      last_counter <= '0;
      win_sum      <= '0;
      win_min      <= '0;
      win_max      <= '0;
      win_count    <= '0;
    end else if (en2) begin
      s2_valid <= s1_valid;
      if (s1_valid && w_taken) begin
        last_counter <= s1_rec.counter;
        if (w_done) begin
          win_sum   <= '0;
          win_min   <= '0;
          win_max   <= '0;
          win_count <= '0;
        end else begin
          win_sum   <= w_sum;
          win_min   <= w_min;
          win_max   <= w_max;
          win_count <= w_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_flags.found <= s1_rec.found;
      s2_flags.taken <= w_taken;
      s2_flags.done  <= w_done;
      s2_sum         <= w_sum;
      s2_min         <= w_min;
      s2_max         <= w_max;
    end
  end

  // Trimmed sum; both sums read as zero when no window finished.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_flags <= s2_flags;
      s3_sum   <= s2_flags.done ? s2_sum : '0;
      s3_trim  <= s2_flags.done ? (s2_sum - s2_min - s2_max) : '0;
    end
  end

  // Division by constants through reciprocal multiplication.
  logic [asta_pkg::PROD_W-1:0] prod_all, prod_trim;

  assign prod_all  = asta_pkg::PROD_W'(s3_sum)  * asta_pkg::PROD_W'(asta_pkg::ALL_RECIP);
  assign prod_trim = asta_pkg::PROD_W'(s3_trim) * asta_pkg::PROD_W'(asta_pkg::TRIM_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en4) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_flags     <= s3_flags;
      s4_mean_all  <= prod_all[asta_pkg::ALL_SH +: W];
      s4_mean_trim <= prod_trim[asta_pkg::TRIM_SH +: W];
    end
  end

  // Alarm decision and output register.
  logic alarm_next;

  always_comb begin
    alarm_next = alarm_state;
    if (s4_flags.done && notify_enable) begin
      alarm_next = s4_mean_trim > alarm_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      alarm_state <= 1'b0;
    end else begin
      if (en5) begin
        out_valid <= s4_valid;
      end
      if (cfg_write && cfg_index == asta_pkg::REG_NOTIFY_ENABLE && !cfg_data[0]) begin
        alarm_state <= 1'b0;
      end else if (en5 && s4_valid) begin
        alarm_state <= alarm_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_flags     <= s4_flags;
      out_mean_all  <= s4_mean_all;
      out_mean_trim <= s4_mean_trim;
      out_alarm     <= alarm_next;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.name_found   = out_flags.found;
  assign result_out.sample_taken = out_flags.taken;
  assign result_out.window_done  = out_flags.done;
  assign result_out.mean_all     = out_mean_all;
  assign result_out.mean_trimmed = out_mean_trim;
  assign result_out.alarm        = out_alarm;

  // The window always restarts before it reaches its full length.
  assert property (@(posedge clk) disable iff (rst)
    win_count < asta_pkg::COUNT_W'(asta_pkg::WINDOW_LEN))
    else $error("window count reached the window length");

  // A packet record that cannot move on must not be overwritten.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !en2) |=> (s1_valid && $stable(s1_rec)))
    else $error("stalled packet record changed");

  // A finished window implies a stored sample, and no window means zero means.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_flags.done) |-> (out_mean_all == '0 && out_mean_trim == '0))
    else $error("means nonzero without a finished window");

  assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_flags.done) |-> s2_flags.taken)
    else $error("window finished without a sample");

  // Disabling notification clears the alarm.
  assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_index == asta_pkg::REG_NOTIFY_ENABLE && !cfg_data[0]) |=> !alarm_state)
    else $error("alarm still set after notification was disabled");

endmodule

`default_nettype wire

// ----- sim/asta_window_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor advertisement sampler - result checker
// Watches the byte and result channels and the register port, and predicts
// each packet result from the bytes the block accepts. Every result the
// block hands out is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module asta_window_checker (
  input  logic                             clk,
  input  logic                             rst,
  asta_in_if                               byte_ch,
  asta_out_if                              res_ch,
  input  logic                             cfg_write,
  input  logic [asta_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [asta_pkg::DATA_W-1:0]      cfg_data,
  output int                               mismatches,
  output int                               pending,
  output int                               windows_closed,
  output int                               alarm_windows
);
  import asta_pkg::*;

  typedef struct packed {
    logic        found;
    logic        taken;
    logic        done;
    logic [31:0] mean_all;
    logic [31:0] mean_trim;
    logic        alarm;
  } pkt_result_t;

  // Register copies.
  logic [31:0] threshold;
  logic        notify_on;

  // Packet walk state.
  logic [7:0]  pos;
  logic [8:0]  field_next;
  logic [7:0]  hist [6];
  logic [6:0]  marks;
  logic        prefix_hit;
  logic [31:0] ctr_word;
  logic [31:0] ppm_word;

  // Window state.
  logic [31:0] prev_ctr;
  logic [31:0] win_sum;
  logic [31:0] win_lo;
  logic [31:0] win_hi;
  logic [2:0]  win_fill;
  logic        alarm_q;

  pkt_result_t expected_results [$];
  int n_bad = 0;
  int n_windows = 0;
  int n_alarm = 0;

  task automatic clear_packet_state();
    pos        = '0;
    field_next = '0;
    foreach (hist[k]) hist[k] = '0;
    marks      = '0;
    prefix_hit = 1'b0;
    ctr_word   = '0;
    ppm_word   = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    pkt_result_t r;
    logic [31:0] trimmed;
    int k;
    // Bytes past the packet limit take no part in the walk.
    if (pos < MAX_ADV_BYTES) begin
      marks = {marks[5:0], 1'b0};
      if ({1'b0, pos} == field_next) begin
        marks[0]   = 1'b1;
        field_next = {1'b0, pos} + {1'b0, b} + 9'd1;
      end
      // A length byte six positions back means hist[4] is its type byte.
      if (marks[6] && (hist[4] == TYPE_NAME_SHORT || hist[4] == TYPE_NAME_FULL) &&
          hist[3] == NAME_PREFIX[0] && hist[2] == NAME_PREFIX[1] &&
          hist[1] == NAME_PREFIX[2] && hist[0] == NAME_PREFIX[3] &&
          b == NAME_PREFIX[4])
        prefix_hit = 1'b1;
      if (pos >= CNT_FIRST && pos < VAL_FIRST)
        ctr_word[8*(pos-CNT_FIRST) +: 8] = b;
      else if (pos >= VAL_FIRST && pos < VAL_FIRST + WORD_BYTES)
        ppm_word[8*(pos-VAL_FIRST) +: 8] = b;
      for (k = 5; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = b;
      pos     = pos + 8'd1;
    end
    if (last) begin
      r       = '0;
      r.found = prefix_hit;
      if (prefix_hit && ctr_word != prev_ctr) begin
        if (win_fill == 0) begin
          win_lo  = ppm_word;
          win_hi  = ppm_word;
          win_sum = '0;
        end else begin
          if (ppm_word < win_lo) win_lo = ppm_word;
          if (ppm_word > win_hi) win_hi = ppm_word;
        end
        win_sum  = win_sum + ppm_word;
        win_fill = win_fill + 3'd1;
        prev_ctr = ctr_word;
        r.taken  = 1'b1;
        if (win_fill >= WINDOW_LEN) begin
          trimmed    = win_sum - win_lo - win_hi;
          r.done     = 1'b1;
          r.mean_all = win_sum / WINDOW_LEN;
          r.mean_trim = trimmed / TRIM_LEN;
          if (notify_on) alarm_q = (r.mean_trim > threshold);
          n_windows++;
          if (alarm_q) n_alarm++;
          win_fill = '0;
          win_sum  = '0;
          win_lo   = '0;
          win_hi   = '0;
        end
      end
      r.alarm = alarm_q;
      expected_results.push_back(r);
      clear_packet_state();
    end
  endtask

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      n_bad++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    pkt_result_t want;
    if (rst) begin
      threshold = '0;
      notify_on = 1'b0;
      clear_packet_state();
      prev_ctr  = '0;
      win_sum   = '0;
      win_lo    = '0;
      win_hi    = '0;
      win_fill  = '0;
      alarm_q   = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ALARM_THRESHOLD: threshold = cfg_data;
          REG_NOTIFY_ENABLE: begin
            notify_on = cfg_data[0];
            if (!notify_on) alarm_q = 1'b0;
          end
          default: ;
        endcase
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          n_bad++;
          $display("%0t: result with nothing expected: found=%0b taken=%0b done=%0b",
                   $time, res_ch.name_found, res_ch.sample_taken, res_ch.window_done);
        end else begin
          want = expected_results.pop_front();
          compare_field("name_found", 32'(want.found), 32'(res_ch.name_found));
          compare_field("sample_taken", 32'(want.taken), 32'(res_ch.sample_taken));
          compare_field("window_done", 32'(want.done), 32'(res_ch.window_done));
          compare_field("mean_all", want.mean_all, res_ch.mean_all);
          compare_field("mean_trimmed", want.mean_trim, res_ch.mean_trimmed);
          compare_field("alarm", 32'(want.alarm), 32'(res_ch.alarm));
        end
      end
      if (byte_ch.valid && byte_ch.ready)
        predict_byte(byte_ch.adv_byte, byte_ch.last_byte);
    end
    mismatches     <= n_bad;
    pending        <= expected_results.size();
    windows_closed <= n_windows;
    alarm_windows  <= n_alarm;
  end

endmodule

// ----- sim/tb_adv_sensor_sample_trimmed_alarm_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor advertisement sampler - testbench top
// Drives advertisement packets (sensor packets, cut and overlong ones, broken
// prefixes, late name fields and noise) under changing alarm settings,
// stalls the result side on its own pattern and reports the checker's verdict.
// ----------------------------------------------------------------------------

module tb_adv_sensor_sample_trimmed_alarm_unit;
  import asta_pkg::*;

  localparam int unsigned RUN_LIMIT    = 200000;
  localparam int unsigned IDLE_HOLD    = 8;
  localparam int unsigned RANDOM_BYTES = 900;

  typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_HOLD_OFF}
    ready_mode_t;
  typedef enum logic [2:0] {PKT_SENSOR, PKT_CUT_SHORT, PKT_OVERLONG, PKT_BAD_PREFIX,
                            PKT_LATE_NAME, PKT_NOISE} pkt_kind_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DATA_W-1:0]      cfg_data;

  asta_in_if  adv_in ();
  asta_out_if result_out ();

  int mismatches;
  int pending;
  int windows_closed;
  int alarm_windows;

  int          cycles = 0;
  int          bytes_sent = 0;
  int          packets_sent = 0;
  int          phases = 0;
  int          burst_left = 0;
  bit          steady_sender = 1'b0;
  logic [31:0] last_ctr_sent = '0;
  ready_mode_t rx_mode = READY_ALWAYS;
  int          rx_left = 0;
  logic [7:0]  pkt [$];

  always #2 clk = ~clk;

  adv_sensor_sample_trimmed_alarm_unit dut (
    .clk        (clk),
    .rst        (rst),
    .adv_in     (adv_in),
    .result_out (result_out),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  asta_window_checker u_window_check (
    .clk            (clk),
    .rst            (rst),
    .byte_ch        (adv_in),
    .res_ch         (result_out),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .windows_closed (windows_closed),
    .alarm_windows  (alarm_windows)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // The result side switches between stall patterns at random.
  always @(posedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = ready_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 60);
      end
      rx_left--;
      case (rx_mode)
        READY_ALWAYS: result_out.ready <= 1'b1;
        READY_COIN:   result_out.ready <= 1'($urandom_range(0, 1));
        READY_SPARSE: result_out.ready <= ($urandom_range(0, 7) == 0);
        default:      result_out.ready <= (rx_left < 4);
      endcase
    end
  end

  task automatic send_item(input logic [7:0] b, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap        = steady_sender ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        adv_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    adv_in.valid     <= 1'b1;
    adv_in.adv_byte  <= b;
    adv_in.last_byte <= l;
    do @(posedge clk); while (!adv_in.ready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_item(pkt[i], i == pkt.size() - 1);
    packets_sent++;
  endtask

  task automatic wait_for_results();
    adv_in.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic program_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [DATA_W-1:0] val);
    wait_for_results();
    // Let the result pipeline settle before touching a register.
    repeat (IDLE_HOLD) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic build_packet(input pkt_kind_t kind);
    logic [31:0] ctr;
    logic [31:0] ppm;
    int extra;
    int n;
    pkt.delete();
    case ($urandom_range(0, 9))
      0:       ctr = last_ctr_sent;
      1:       ctr = '0;
      2:       ctr = last_ctr_sent + 32'd1;
      default: ctr = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0, 1, 2: ppm = $urandom_range(0, 2000);
      3:       ppm = 32'hFFFF_FFFF - $urandom_range(0, 4095);
      4:       ppm = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      default: ppm = $urandom;
    endcase
    extra = $urandom_range(0, 3);
    case (kind)
      PKT_NOISE: begin
        n = $urandom_range(1, 40);
        repeat (n) pkt.push_back(8'($urandom));
      end
      PKT_LATE_NAME: begin
        // A flags field first, so the name field starts at byte three.
        pkt = '{8'h02, 8'h01, 8'h06};
        pkt.push_back(8'($urandom_range(5, 20)));
        pkt.push_back($urandom_range(0, 1) ? TYPE_NAME_FULL : TYPE_NAME_SHORT);
        for (int k = 0; k < PREFIX_LEN; k++) pkt.push_back(NAME_PREFIX[k]);
        n = $urandom_range(3, 10);
        repeat (n) pkt.push_back(8'($urandom));
      end
      default: begin
        // The length covers the rest of the packet, but one packet in four gets a random one.
        pkt.push_back($urandom_range(0, 3) != 0 ? 8'(14 + extra) : 8'($urandom));
        pkt.push_back($urandom_range(0, 1) ? TYPE_NAME_FULL : TYPE_NAME_SHORT);
        for (int k = 0; k < PREFIX_LEN; k++) pkt.push_back(NAME_PREFIX[k]);
        for (int k = 0; k < WORD_BYTES; k++) pkt.push_back(ctr[8*k +: 8]);
        for (int k = 0; k < WORD_BYTES; k++) pkt.push_back(ppm[8*k +: 8]);
        repeat (extra) pkt.push_back(8'($urandom));
        if (kind == PKT_BAD_PREFIX) begin
          n = $urandom_range(1, 6);
          pkt[n] = pkt[n] ^ 8'($urandom_range(1, 255));
        end else if (kind == PKT_CUT_SHORT) begin
          n = $urandom_range(1, 14);
          while (pkt.size() > n) void'(pkt.pop_back());
        end else if (kind == PKT_OVERLONG) begin
          n = $urandom_range(MAX_ADV_BYTES + 1, MAX_ADV_BYTES + 16);
          while (pkt.size() < n) pkt.push_back(8'($urandom));
        end
        last_ctr_sent = ctr;
      end
    endcase
  endtask

  initial begin
    logic [31:0] thr;
    logic        en;
    int          phase_end;
    pkt_kind_t   kind;

    rst               <= 1'b1;
    cfg_write         <= 1'b0;
    cfg_index         <= REG_ALARM_THRESHOLD;
    cfg_data          <= '0;
    adv_in.valid      <= 1'b0;
    adv_in.adv_byte   <= '0;
    adv_in.last_byte  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Single-byte packets at both byte extremes.
    pkt = '{8'hFF};
    send_packet();
    pkt = '{8'h00};
    send_packet();
    // Name cut off by the packet end one byte early.
    pkt = '{8'h06, TYPE_NAME_FULL, NAME_PREFIX[0], NAME_PREFIX[1], NAME_PREFIX[2],
            NAME_PREFIX[3]};
    send_packet();
    // Field length of one with the prefix spilling past it; the counter reads
    // as zero, which matches the reset counter and stores nothing.
    pkt = '{8'h01, TYPE_NAME_SHORT, NAME_PREFIX[0], NAME_PREFIX[1], NAME_PREFIX[2],
            NAME_PREFIX[3], NAME_PREFIX[4]};
    send_packet();
    // One counter byte present, the rest and the value read as zero.
    pkt = '{8'h07, TYPE_NAME_FULL, NAME_PREFIX[0], NAME_PREFIX[1], NAME_PREFIX[2],
            NAME_PREFIX[3], NAME_PREFIX[4], 8'h01};
    send_packet();
    last_ctr_sent = 32'd1;

    phase_end = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < phase_end) begin
      case (phases % 6)
        0: begin en = 1'b1; thr = 32'h0; end
        1: begin en = 1'b1; thr = 32'hFFFF_FFFF; end
        2: begin en = 1'b1; thr = $urandom_range(0, 3000); end
        3: begin en = 1'b0; thr = $urandom; end
        4: begin en = 1'b1; thr = $urandom; end
        default: begin en = 1'b1; thr = $urandom_range(0, 2000); end
      endcase
      program_register(REG_ALARM_THRESHOLD, thr);
      program_register(REG_NOTIFY_ENABLE, DATA_W'(en));
      steady_sender = (phases % 3 == 1);
      phases++;
      repeat ($urandom_range(6, 9)) begin
        case ($urandom_range(0, 11))
          0, 1, 2, 3, 4, 5: kind = PKT_SENSOR;
          6:                kind = PKT_CUT_SHORT;
          7:                kind = PKT_OVERLONG;
          8:                kind = PKT_BAD_PREFIX;
          9, 10:            kind = PKT_LATE_NAME;
          default:          kind = PKT_NOISE;
        endcase
        build_packet(kind);
        send_packet();
        if ($urandom_range(0, 19) == 0) wait_for_results();
      end
    end

    wait_for_results();
    repeat (12) @(posedge clk);
    $display("Sent %0d bytes in %0d packets across %0d alarm settings.",
             bytes_sent, packets_sent, phases);
    $display("Checked %0d finished windows, %0d of them leaving the alarm raised.",
             windows_closed, alarm_windows);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
